/* sv/tli_pkg.sv */
// Shared types and constants for the travel limit identifier.
`timescale 1ns / 1ps

package tli_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int MIN_W      = 16;
    localparam int EXP_W      = 18;
    localparam int MARGIN_W   = 16;
    localparam int ERR_W      = 20;
    localparam int QUAL_W     = 2;
    localparam int DIR_W      = 2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SAMPLES     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FALLBACK_OPEN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FALLBACK_CLOSED = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPECTED_TRAVEL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SAFE_MARGIN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SOFT_MARGIN     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_TRAVEL_ERR  = 3'd6;

    localparam logic [DIR_W-1:0] DIR_OPEN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CLOSE = 2'd2;

    localparam logic [QUAL_W-1:0] QUAL_VERIFIED     = 2'd0;
    localparam logic [QUAL_W-1:0] QUAL_CONSERVATIVE = 2'd1;
    localparam logic [QUAL_W-1:0] QUAL_INVALID      = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMP,
        ST_TRAV,
        ST_DIFF,
        ST_ABS,
        ST_ERRC,
        ST_SOPEN,
        ST_SCLOSED,
        ST_WOPEN,
        ST_WCLOSED,
        ST_ORD,
        ST_LOAD
    } state_t;

    // fixed-width configuration fields
    typedef struct packed {
        logic [MIN_W-1:0]    min_samples;
        logic [EXP_W-1:0]    expected_travel;
        logic [MARGIN_W-1:0] safe_margin;
        logic [MARGIN_W-1:0] soft_margin;
        logic [ERR_W-1:0]    max_travel_error;
    } cfg_t;

endpackage

/* sv/tli_alu.sv */
// Shared add/subtract unit with sign flag.
`timescale 1ns / 1ps

module tli_alu #(
    parameter int WIDTH = 23
) (
    input  tli_pkg::op_t             op,
    input  logic signed [WIDTH-1:0]  a,
    input  logic signed [WIDTH-1:0]  b,
    output logic signed [WIDTH-1:0]  y,
    output logic                     neg
);
    import tli_pkg::*;

    always_comb begin
        unique case (op)
            OP_ADD:  y = a + b;
            OP_SUB:  y = a - b;
            default: y = a - b;
        endcase
    end

    assign neg = y[WIDTH-1];

endmodule

/* sv/tli_core.sv */
// Sequencer, batch state and result registers around the shared adder.
`timescale 1ns / 1ps

module tli_core #(
    parameter int POSITION_BITS = 19,
    parameter int COUNT_BITS    = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tli_pkg::cfg_t                   cfg,
    input  logic signed [POSITION_BITS-1:0] fallback_open,
    input  logic signed [POSITION_BITS-1:0] fallback_closed,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            sample_present,
    input  logic [1:0]                      direction,
    input  logic                            limit_seen,
    input  logic                            jam_seen,
    input  logic                            stop_triggered,
    input  logic signed [POSITION_BITS-1:0] position,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [COUNT_BITS-1:0]           total_count,
    output logic [COUNT_BITS-1:0]           valid_count,
    output logic [COUNT_BITS-1:0]           rejected_count,
    output logic signed [POSITION_BITS-1:0] open_stop,
    output logic signed [POSITION_BITS-1:0] closed_stop,
    output logic signed [POSITION_BITS:0]   stroke_len,
    output logic [19:0]                     travel_error,
    output logic signed [POSITION_BITS:0]   safe_open,
    output logic signed [POSITION_BITS:0]   safe_closed,
    output logic signed [POSITION_BITS:0]   soft_open,
    output logic signed [POSITION_BITS:0]   soft_closed,
    output logic [1:0]                      quality
);
    import tli_pkg::*;

    localparam int P   = POSITION_BITS;
    localparam int C   = COUNT_BITS;
    localparam int WW  = ((P > ERR_W) ? P : ERR_W) + 3;
    localparam int CMW = (C > MIN_W) ? C : MIN_W;
    localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};
    localparam logic [C-1:0]        CNT_MAX = {C{1'b1}};

    state_t state_reg, state_next;

    logic signed [P-1:0] open_min_reg, closed_max_reg, pos_reg, lo_reg, hi_reg;
    logic [C-1:0] open_cnt_reg, closed_cnt_reg, seen_cnt_reg, good_cnt_reg, bad_cnt_reg;
    logic is_open_reg, last_reg;
    logic signed [WW-1:0] travel_reg, err_reg, s_open_reg, s_closed_reg;
    logic signed [WW-1:0] w_open_reg, w_closed_reg;
    logic enough_reg, err_ok_reg, ordered_reg;

    logic out_valid_reg;
    logic [C-1:0] total_out_reg, valid_out_reg, rej_out_reg;
    logic signed [P-1:0] open_out_reg, closed_out_reg;
    logic signed [P:0] travel_out_reg, s_open_out_reg, s_closed_out_reg;
    logic signed [P:0] w_open_out_reg, w_closed_out_reg;
    logic [ERR_W-1:0] err_out_reg;
    logic [QUAL_W-1:0] qual_out_reg;

    op_t                 alu_op;
    logic signed [WW-1:0] alu_a, alu_b, alu_y;
    logic                alu_neg;

    logic accept, sample_ok, load, out_free;
    logic open_trusted, closed_trusted;
    logic signed [P-1:0] lo_sel, hi_sel;
    logic [QUAL_W-1:0] qual;

    tli_alu #(.WIDTH(WW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y),
        .neg (alu_neg)
    );

    assign accept    = in_valid && in_ready;
    assign sample_ok = (direction == DIR_OPEN || direction == DIR_CLOSE) && limit_seen &&
                       !jam_seen && !stop_triggered;
    assign out_free  = !out_valid_reg || out_ready;
    assign load      = (state_reg == ST_LOAD) && out_free;

    assign open_trusted   = CMW'(open_cnt_reg) >= CMW'(cfg.min_samples);
    assign closed_trusted = CMW'(closed_cnt_reg) >= CMW'(cfg.min_samples);
    assign lo_sel         = open_trusted ? open_min_reg : fallback_open;
    assign hi_sel         = closed_trusted ? closed_max_reg : fallback_closed;

    always_comb begin
        if (enough_reg && ordered_reg && err_ok_reg) begin
            qual = QUAL_VERIFIED;
        end else if (ordered_reg) begin
            qual = QUAL_CONSERVATIVE;
        end else begin
            qual = QUAL_INVALID;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sample_present && sample_ok) begin
                        state_next = ST_CMP;
                    end else if (last) begin
                        state_next = ST_TRAV;
                    end
                end
            end
            ST_CMP:     state_next = last_reg ? ST_TRAV : ST_IDLE;
            ST_TRAV:    state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_ABS;
            ST_ABS:     state_next = ST_ERRC;
            ST_ERRC:    state_next = ST_SOPEN;
            ST_SOPEN:   state_next = ST_SCLOSED;
            ST_SCLOSED: state_next = ST_WOPEN;
            ST_WOPEN:   state_next = ST_WCLOSED;
            ST_WCLOSED: state_next = ST_ORD;
            ST_ORD:     state_next = ST_LOAD;
            ST_LOAD:    state_next = out_free ? ST_IDLE : ST_LOAD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and adder operand selection
    always_comb begin
        in_ready = 1'b0;
        alu_op   = OP_SUB;
        alu_a    = '0;
        alu_b    = '0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_CMP: begin
                // open: pos < min ; closed: max < pos
                alu_a = is_open_reg ? WW'(pos_reg) : WW'(closed_max_reg);
                alu_b = is_open_reg ? WW'(open_min_reg) : WW'(pos_reg);
            end
            ST_TRAV: begin
                alu_a = WW'(hi_sel);
                alu_b = WW'(lo_sel);
            end
            ST_DIFF: begin
                alu_a = travel_reg;
                alu_b = WW'(cfg.expected_travel);
            end
            ST_ABS: begin
                alu_op = err_reg[WW-1] ? OP_SUB : OP_ADD;
                alu_a  = err_reg[WW-1] ? '0 : err_reg;
                alu_b  = err_reg[WW-1] ? err_reg : '0;
            end
            ST_ERRC: begin
                alu_a = WW'(cfg.max_travel_error);
                alu_b = err_reg;
            end
            ST_SOPEN: begin
                alu_op = OP_ADD;
                alu_a  = WW'(lo_reg);
                alu_b  = WW'(cfg.safe_margin);
            end
            ST_SCLOSED: begin
                alu_a = WW'(hi_reg);
                alu_b = WW'(cfg.safe_margin);
            end
            ST_WOPEN: begin
                alu_op = OP_ADD;
                alu_a  = WW'(lo_reg);
                alu_b  = WW'(cfg.soft_margin);
            end
            ST_WCLOSED: begin
                alu_a = WW'(hi_reg);
                alu_b = WW'(cfg.soft_margin);
            end
            ST_ORD: begin
                alu_a = w_open_reg;
                alu_b = w_closed_reg;
            end
            ST_LOAD: ;
            default: ;
        endcase
    end

    // control state and batch trackers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            open_min_reg   <= POS_MAX;
            closed_max_reg <= POS_MIN;
            open_cnt_reg   <= '0;
            closed_cnt_reg <= '0;
            seen_cnt_reg   <= '0;
            good_cnt_reg   <= '0;
            bad_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && sample_present) begin
                if (seen_cnt_reg != CNT_MAX) seen_cnt_reg <= seen_cnt_reg + 1'b1;
                if (!sample_ok) begin
                    if (bad_cnt_reg != CNT_MAX) bad_cnt_reg <= bad_cnt_reg + 1'b1;
                end else begin
                    if (good_cnt_reg != CNT_MAX) good_cnt_reg <= good_cnt_reg + 1'b1;
                    if (direction == DIR_OPEN) begin
                        if (open_cnt_reg != CNT_MAX) open_cnt_reg <= open_cnt_reg + 1'b1;
                    end else begin
                        if (closed_cnt_reg != CNT_MAX)
                            closed_cnt_reg <= closed_cnt_reg + 1'b1;
                    end
                end
            end
            if (state_reg == ST_CMP && alu_neg) begin
                if (is_open_reg) open_min_reg <= pos_reg;
                else             closed_max_reg <= pos_reg;
            end
            if (load) begin
                open_min_reg   <= POS_MAX;
                closed_max_reg <= POS_MIN;
                open_cnt_reg   <= '0;
                closed_cnt_reg <= '0;
                seen_cnt_reg   <= '0;
                good_cnt_reg   <= '0;
                bad_cnt_reg    <= '0;
                out_valid_reg  <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg     <= position;
            is_open_reg <= (direction == DIR_OPEN);
            last_reg    <= last;
        end
        unique case (state_reg)
            ST_TRAV: begin
                travel_reg <= alu_y;
                lo_reg     <= lo_sel;
                hi_reg     <= hi_sel;
                enough_reg <= open_trusted && closed_trusted;
            end
            ST_DIFF:    err_reg      <= alu_y;
            ST_ABS:     err_reg      <= alu_y;
            ST_ERRC:    err_ok_reg   <= !alu_neg;
            ST_SOPEN:   s_open_reg   <= alu_y;
            ST_SCLOSED: s_closed_reg <= alu_y;
            ST_WOPEN:   w_open_reg   <= alu_y;
            ST_WCLOSED: w_closed_reg <= alu_y;
            ST_ORD:     ordered_reg  <= alu_neg;
            default: ;
        endcase
        if (load) begin
            total_out_reg    <= seen_cnt_reg;
            valid_out_reg    <= good_cnt_reg;
            rej_out_reg      <= bad_cnt_reg;
            open_out_reg     <= lo_reg;
            closed_out_reg   <= hi_reg;
            travel_out_reg   <= travel_reg[P:0];
            err_out_reg      <= err_reg[ERR_W-1:0];
            s_open_out_reg   <= s_open_reg[P:0];
            s_closed_out_reg <= s_closed_reg[P:0];
            w_open_out_reg   <= w_open_reg[P:0];
            w_closed_out_reg <= w_closed_reg[P:0];
            qual_out_reg     <= qual;
        end
    end

    assign out_valid      = out_valid_reg;
    assign total_count    = total_out_reg;
    assign valid_count    = valid_out_reg;
    assign rejected_count = rej_out_reg;
    assign open_stop      = open_out_reg;
    assign closed_stop    = closed_out_reg;
    assign stroke_len     = travel_out_reg;
    assign travel_error   = err_out_reg;
    assign safe_open      = s_open_out_reg;
    assign safe_closed    = s_closed_out_reg;
    assign soft_open      = w_open_out_reg;
    assign soft_closed    = w_closed_out_reg;
    assign quality        = qual_out_reg;

endmodule

/* sv/travel_limit_identifier_top.sv */
// Top level: stream ports, configuration registers and the batch core.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: present, direction; tdata: flags, position; tlast
//  m_*       out  m_tvalid/m_tready  tuser: quality; tdata: counts, limits, travel, margins
//  cfg_*     in   cfg_wr_en          cfg_addr selects register, cfg_wdata value
//
// A rejected or empty item is only accepted; a valid sample is accepted and then gets a
// min/max compare through the shared adder. The last item adds 9 adder steps plus
// one load step, which waits while the previous result is still held in the output
// register. Reset is synchronous, active low, and clears the trackers, counters and
// output valid; it sets min_samples to 1 and clears the rest of the configuration.
`timescale 1ns / 1ps

module travel_limit_identifier_top #(
    parameter int POSITION_BITS = 19,
    parameter int COUNT_BITS    = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          cfg_wr_en,
    input  logic [tli_pkg::CFG_ADDR_W-1:0]                cfg_addr,
    input  logic [((POSITION_BITS > 20) ? POSITION_BITS : 20)-1:0] cfg_wdata,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // limit_seen, jam_seen, stop_triggered, position, zero fill
    input  logic [((POSITION_BITS + 3 + 7) / 8) * 8 - 1:0] s_tdata,
    // sample_present, direction
    input  logic [2:0]                                    s_tuser,
    input  logic                                          s_tlast,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // total_count, valid_count, rejected_count, open_stop, closed_stop,
    // stroke_len, travel_error, safe_open, safe_closed, soft_open, soft_closed, zero fill
    output logic [((3 * COUNT_BITS + 7 * POSITION_BITS + 25 + 7) / 8) * 8 - 1:0] m_tdata,
    // quality
    output logic [1:0]                                    m_tuser
);
    import tli_pkg::*;

    localparam int P      = POSITION_BITS;
    localparam int C      = COUNT_BITS;
    localparam int OUT_W  = ((3 * C + 7 * P + 25 + 7) / 8) * 8;

    cfg_t cfg_reg;
    logic signed [P-1:0] fb_open_reg, fb_closed_reg;

    logic [C-1:0] total_count, valid_count, rejected_count;
    logic signed [P-1:0] open_stop, closed_stop;
    logic signed [P:0] stroke_len, safe_open, safe_closed, soft_open, soft_closed;
    logic [ERR_W-1:0] travel_error;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_samples      <= MIN_W'(1);
            cfg_reg.expected_travel  <= '0;
            cfg_reg.safe_margin      <= '0;
            cfg_reg.soft_margin      <= '0;
            cfg_reg.max_travel_error <= '0;
            fb_open_reg              <= '0;
            fb_closed_reg            <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MIN_SAMPLES:     cfg_reg.min_samples      <= cfg_wdata[MIN_W-1:0];
                REG_FALLBACK_OPEN:   fb_open_reg              <= cfg_wdata[P-1:0];
                REG_FALLBACK_CLOSED: fb_closed_reg            <= cfg_wdata[P-1:0];
                REG_EXPECTED_TRAVEL: cfg_reg.expected_travel  <= cfg_wdata[EXP_W-1:0];
                REG_SAFE_MARGIN:     cfg_reg.safe_margin      <= cfg_wdata[MARGIN_W-1:0];
                REG_SOFT_MARGIN:     cfg_reg.soft_margin      <= cfg_wdata[MARGIN_W-1:0];
                REG_MAX_TRAVEL_ERR:  cfg_reg.max_travel_error <= cfg_wdata[ERR_W-1:0];
                default: ;
            endcase
        end
    end

    tli_core #(
        .POSITION_BITS (P),
        .COUNT_BITS    (C)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .fallback_open   (fb_open_reg),
        .fallback_closed (fb_closed_reg),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .sample_present  (s_tuser[0]),
        .direction       (s_tuser[2:1]),
        .limit_seen      (s_tdata[0]),
        .jam_seen        (s_tdata[1]),
        .stop_triggered  (s_tdata[2]),
        .position        (s_tdata[P+2:3]),
        .last            (s_tlast),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .total_count     (total_count),
        .valid_count     (valid_count),
        .rejected_count  (rejected_count),
        .open_stop       (open_stop),
        .closed_stop     (closed_stop),
        .stroke_len      (stroke_len),
        .travel_error    (travel_error),
        .safe_open       (safe_open),
        .safe_closed     (safe_closed),
        .soft_open       (soft_open),
        .soft_closed     (soft_closed),
        .quality         (m_tuser)
    );

    assign m_tdata = OUT_W'({soft_closed, soft_open, safe_closed, safe_open, travel_error,
                             stroke_len, closed_stop, open_stop, rejected_count,
                             valid_count, total_count});

endmodule

/* sv/tli_checker.sv */
// Port-level assertions for the travel limit identifier, bound to the top level.
`timescale 1ns / 1ps

module tli_checker #(
    parameter int POSITION_BITS = 19,
    parameter int COUNT_BITS    = 16
) (
    input logic                                          aclk,
    input logic                                          aresetn,
    input logic                                          cfg_wr_en,
    input logic [tli_pkg::CFG_ADDR_W-1:0]                cfg_addr,
    input logic [((POSITION_BITS > 20) ? POSITION_BITS : 20)-1:0] cfg_wdata,
    input logic                                          s_tvalid,
    input logic                                          s_tready,
    input logic [((POSITION_BITS + 3 + 7) / 8) * 8 - 1:0] s_tdata,
    input logic [2:0]                                    s_tuser,
    input logic                                          s_tlast,
    input logic                                          m_tvalid,
    input logic                                          m_tready,
    input logic [((3 * COUNT_BITS + 7 * POSITION_BITS + 25 + 7) / 8) * 8 - 1:0] m_tdata,
    input logic [1:0]                                    m_tuser
);
    import tli_pkg::*;

    localparam int P     = POSITION_BITS;
    localparam int C     = COUNT_BITS;
    localparam int O_OPN = 3 * C;
    localparam int O_CLS = O_OPN + P;
    localparam int O_TRV = O_CLS + P;

    logic [C:0] total_w, sum_w;
    logic signed [P:0] open_w, closed_w, travel_w;
    logic cfg_seen;

    assign total_w  = (C+1)'(m_tdata[C-1:0]);
    assign sum_w    = (C+1)'(m_tdata[2*C-1:C]) + (C+1)'(m_tdata[3*C-1:2*C]);
    assign open_w   = (P+1)'(signed'(m_tdata[O_OPN+P-1:O_OPN]));
    assign closed_w = (P+1)'(signed'(m_tdata[O_CLS+P-1:O_CLS]));
    assign travel_w = m_tdata[O_TRV+P:O_TRV];
    assign cfg_seen = cfg_wr_en && (cfg_addr != REG_MIN_SAMPLES || cfg_wdata != '0);

    // the last beat of a batch always starts the closing sequence
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast && !cfg_seen) |=> !s_tready)
        else $error("input ready after last beat");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && total_w != {1'b0, {C{1'b1}}}) |-> (sum_w == total_w))
        else $error("valid plus rejected differs from total");

    a_travel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (travel_w == closed_w - open_w))
        else $error("learned travel does not match limits");

endmodule

bind travel_limit_identifier_top tli_checker #(
    .POSITION_BITS (POSITION_BITS),
    .COUNT_BITS    (COUNT_BITS)
) u_tli_checker (.*);

/* bench/tb_travel_limit_identifier_top.sv */
// Self-checking bench for the travel limit identifier: batches of samples in, summaries out.
`timescale 1ns / 1ps

module tb_travel_limit_identifier_top;
    import tli_pkg::*;

    localparam int    STALL_LIMIT   = 5000;
    localparam int    SETTLE_CYCLES = 24;
    localparam longint POS_MAX      = 262143;
    localparam longint POS_MIN      = -262144;

    localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SPARE   = 2'd3;

    typedef struct {
        bit                 present;
        logic [DIR_W-1:0]   dir;
        bit                 limit_hit;
        bit                 jammed;
        bit                 stopped;
        logic signed [18:0] pos;
        bit                 last;
    } stroke_beat_t;

    // m_tdata layout, top field first
    typedef struct packed {
        logic [1:0]  fill;
        logic [19:0] soft_closed;
        logic [19:0] soft_open;
        logic [19:0] safe_closed;
        logic [19:0] safe_open;
        logic [19:0] travel_error;
        logic [19:0] stroke_len;
        logic [18:0] closed_stop;
        logic [18:0] open_stop;
        logic [15:0] rejected_count;
        logic [15:0] valid_count;
        logic [15:0] total_count;
    } travel_body_t;

    typedef struct {
        travel_body_t     body;
        logic [QUAL_W-1:0] quality;
    } travel_summary_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_addr  = '0;
    logic [19:0]  cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata   = '0;
    logic [2:0]   s_tuser   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [207:0] m_tdata;
    logic [1:0]   m_tuser;

    travel_limit_identifier_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // limit_seen, jam_seen, stop_triggered, position, zero fill
        .s_tuser   (s_tuser),   // sample_present, direction
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // counts, limits, travel, error, safe and soft limits, zero fill
        .m_tuser   (m_tuser)    // quality
    );

    always #10 aclk = ~aclk;

    stroke_beat_t    sample_q[$];
    travel_summary_t summary_q[$];
    stroke_beat_t    cur_beat;
    int unsigned     queued_beats = 0;
    int unsigned     mismatches   = 0;
    int unsigned     stall_cycles = 0;
    bit              calm         = 1'b0;

    // shadow of the configuration registers
    logic [15:0]        lim_min_samples = 16'd1;
    logic signed [18:0] lim_fb_open     = '0;
    logic signed [18:0] lim_fb_closed   = '0;
    logic [17:0]        lim_expected    = '0;
    logic [15:0]        lim_safe        = '0;
    logic [15:0]        lim_soft        = '0;
    logic [19:0]        lim_max_err     = '0;

    // batch trackers
    logic signed [18:0] open_min       = 19'h3FFFF;
    logic signed [18:0] closed_max     = 19'h40000;
    logic [15:0]        open_samples   = '0;
    logic [15:0]        closed_samples = '0;
    logic [15:0]        seen_samples   = '0;
    logic [15:0]        good_samples   = '0;
    logic [15:0]        bad_samples    = '0;

    function automatic logic [15:0] sat_inc(logic [15:0] c);
        return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function automatic void track_sample(stroke_beat_t b);
        bit              ok;
        bit              enough_o;
        bit              enough_c;
        bit              ordered;
        longint          lo;
        longint          hi;
        longint          travel;
        longint          diff;
        longint          err;
        longint          wo;
        longint          wc;
        travel_summary_t res;
        if (b.present) begin
            ok = (b.dir == DIR_OPEN || b.dir == DIR_CLOSE) && b.limit_hit &&
                 !b.jammed && !b.stopped;
            seen_samples = sat_inc(seen_samples);
            if (!ok) begin
                bad_samples = sat_inc(bad_samples);
            end else begin
                good_samples = sat_inc(good_samples);
                if (b.dir == DIR_OPEN) begin
                    if (b.pos < open_min) open_min = b.pos;
                    open_samples = sat_inc(open_samples);
                end else begin
                    if (b.pos > closed_max) closed_max = b.pos;
                    closed_samples = sat_inc(closed_samples);
                end
            end
        end
        if (!b.last) return;

        enough_o = open_samples >= lim_min_samples;
        enough_c = closed_samples >= lim_min_samples;
        lo = enough_o ? longint'(open_min) : longint'(lim_fb_open);
        hi = enough_c ? longint'(closed_max) : longint'(lim_fb_closed);
        travel = hi - lo;
        diff = travel - longint'(lim_expected);
        err = (diff < 0) ? -diff : diff;
        wo = lo + longint'(lim_soft);
        wc = hi - longint'(lim_soft);
        ordered = wo < wc;

        res.body.fill           = '0;
        res.body.total_count    = seen_samples;
        res.body.valid_count    = good_samples;
        res.body.rejected_count = bad_samples;
        res.body.open_stop      = 19'(lo);
        res.body.closed_stop    = 19'(hi);
        res.body.stroke_len     = 20'(travel);
        res.body.travel_error   = 20'(err);
        res.body.safe_open      = 20'(lo + longint'(lim_safe));
        res.body.safe_closed    = 20'(hi - longint'(lim_safe));
        res.body.soft_open      = 20'(wo);
        res.body.soft_closed    = 20'(wc);
        if (enough_o && enough_c && ordered && err <= longint'(lim_max_err))
            res.quality = QUAL_VERIFIED;
        else if (ordered)
            res.quality = QUAL_CONSERVATIVE;
        else
            res.quality = QUAL_INVALID;
        summary_q.push_back(res);

        open_min       = 19'h3FFFF;
        closed_max     = 19'h40000;
        open_samples   = '0;
        closed_samples = '0;
        seen_samples   = '0;
        good_samples   = '0;
        bad_samples    = '0;
    endfunction

    function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // sender: one beat per handshake, random gaps unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) track_sample(cur_beat);
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
                    cur_beat = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_beat.pos, cur_beat.stopped, cur_beat.jammed,
                                 cur_beat.limit_hit};
                    s_tuser  <= {cur_beat.dir, cur_beat.present};
                    s_tlast  <= cur_beat.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random backpressure, compare each summary beat
    always @(posedge aclk) begin
        travel_body_t    got;
        travel_summary_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (summary_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected summary beat: %h", m_tdata);
                end else begin
                    want = summary_q.pop_front();
                    check_field("total_count", want.body.total_count, got.total_count);
                    check_field("valid_count", want.body.valid_count, got.valid_count);
                    check_field("rejected_count", want.body.rejected_count,
                                got.rejected_count);
                    check_field("open_stop", want.body.open_stop, got.open_stop);
                    check_field("closed_stop", want.body.closed_stop, got.closed_stop);
                    check_field("stroke_len", want.body.stroke_len, got.stroke_len);
                    check_field("travel_error", want.body.travel_error, got.travel_error);
                    check_field("safe_open", want.body.safe_open, got.safe_open);
                    check_field("safe_closed", want.body.safe_closed, got.safe_closed);
                    check_field("soft_open", want.body.soft_open, got.soft_open);
                    check_field("soft_closed", want.body.soft_closed, got.soft_closed);
                    check_field("quality", want.quality, m_tuser);
                end
            end
            m_tready <= calm || $urandom_range(99) >= 13;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void queue_beat(bit present, logic [1:0] dir, bit lim, bit jam,
                                       bit stp, longint pos, bit last);
        stroke_beat_t b;
        b.present   = present;
        b.dir       = dir;
        b.limit_hit = lim;
        b.jammed    = jam;
        b.stopped   = stp;
        if (pos > POS_MAX)      b.pos = 19'(POS_MAX);
        else if (pos < POS_MIN) b.pos = 19'(POS_MIN);
        else                    b.pos = 19'(pos);
        b.last = last;
        sample_q.push_back(b);
        queued_beats++;
    endfunction

    function automatic longint any_pos();
        return longint'($urandom_range(524287)) + POS_MIN;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MIN_SAMPLES:     lim_min_samples = val[15:0];
            REG_FALLBACK_OPEN:   lim_fb_open     = val[18:0];
            REG_FALLBACK_CLOSED: lim_fb_closed   = val[18:0];
            REG_EXPECTED_TRAVEL: lim_expected    = val[17:0];
            REG_SAFE_MARGIN:     lim_safe        = val[15:0];
            REG_SOFT_MARGIN:     lim_soft        = val[15:0];
            REG_MAX_TRAVEL_ERR:  lim_max_err     = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every beat to go in and every summary to come out, then let the core settle
    task automatic drain();
        do begin
            while (sample_q.size() != 0 || s_tvalid || summary_q.size() != 0)
                @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end while (sample_q.size() != 0 || s_tvalid || summary_q.size() != 0);
    endtask

    task automatic write_all(longint ms, longint fo, longint fc, longint ex, longint sa,
                             longint so, longint me);
        write_reg(REG_MIN_SAMPLES, 20'(ms));
        write_reg(REG_FALLBACK_OPEN, 20'(fo));
        write_reg(REG_FALLBACK_CLOSED, 20'(fc));
        write_reg(REG_EXPECTED_TRAVEL, 20'(ex));
        write_reg(REG_SAFE_MARGIN, 20'(sa));
        write_reg(REG_SOFT_MARGIN, 20'(so));
        write_reg(REG_MAX_TRAVEL_ERR, 20'(me));
    endtask

    task automatic randomize_limits();
        longint ms;
        longint ex;
        longint sa;
        longint so;
        longint me;
        case ($urandom_range(7))
            0:       ms = 0;
            1:       ms = 65535;
            default: ms = $urandom_range(1, 3);
        endcase
        ex = ($urandom_range(7) == 0) ? 262143 : longint'($urandom_range(262143));
        sa = ($urandom_range(3) == 0) ? 65535 : longint'($urandom_range(2000));
        so = ($urandom_range(3) == 0) ? 65535 : longint'($urandom_range(2000));
        case ($urandom_range(3))
            0:       me = 0;
            1:       me = 1048575;
            default: me = $urandom_range(2000);
        endcase
        write_all(ms, any_pos(), any_pos(), ex, sa, so, me);
    endtask

    // mostly good strokes clustered around the expected travel, some rejects and noise
    task automatic queue_random_batch();
        int unsigned      len;
        int unsigned      r;
        bit               tail_empty;
        bit               last;
        bit               lim;
        bit               jam;
        bit               stp;
        longint           o_base;
        longint           c_base;
        longint           pos;
        logic [DIR_W-1:0] dir;
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        tail_empty = ($urandom_range(9) == 0);
        o_base = -longint'(lim_expected / 2) + longint'($urandom_range(200)) - 100;
        c_base = o_base + longint'(lim_expected);
        for (int k = 0; k < len; k++) begin
            last = (k == len - 1) && !tail_empty;
            r = $urandom_range(99);
            dir = $urandom_range(1) ? DIR_OPEN : DIR_CLOSE;
            pos = ((dir == DIR_OPEN) ? o_base : c_base) + longint'($urandom_range(400)) - 200;
            lim = 1'b1;
            jam = 1'b0;
            stp = 1'b0;
            if (r < 72) begin
                queue_beat(1'b1, dir, lim, jam, stp, pos, last);
            end else if (r < 88) begin
                case ($urandom_range(3))
                    0:       dir = $urandom_range(1) ? DIR_UNKNOWN : DIR_SPARE;
                    1:       lim = 1'b0;
                    2:       jam = 1'b1;
                    default: stp = 1'b1;
                endcase
                queue_beat(1'b1, dir, lim, jam, stp, pos, last);
            end else if (r < 94) begin
                queue_beat(1'b0, 2'($urandom_range(3)), 1'($urandom), 1'($urandom),
                           1'($urandom), any_pos(), last);
            end else begin
                queue_beat(1'($urandom), 2'($urandom_range(3)), 1'($urandom),
                           1'($urandom), 1'($urandom), any_pos(), last);
            end
        end
        if (tail_empty) queue_beat(1'b0, DIR_UNKNOWN, 1'b0, 1'b0, 1'b0, 0, 1'b1);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: empty batch, full-range limits, rejects of every kind
        queue_beat(1'b0, DIR_UNKNOWN, 1'b0, 1'b0, 1'b0, 0, 1'b1);
        queue_beat(1'b1, DIR_OPEN, 1'b1, 1'b0, 1'b0, POS_MIN, 1'b0);
        queue_beat(1'b1, DIR_CLOSE, 1'b1, 1'b0, 1'b0, POS_MAX, 1'b0);
        queue_beat(1'b0, DIR_OPEN, 1'b1, 1'b0, 1'b0, 0, 1'b1);
        queue_beat(1'b1, DIR_UNKNOWN, 1'b1, 1'b0, 1'b0, 100, 1'b0);
        queue_beat(1'b1, DIR_SPARE, 1'b1, 1'b0, 1'b0, 100, 1'b0);
        queue_beat(1'b1, DIR_OPEN, 1'b0, 1'b0, 1'b0, -5, 1'b0);
        queue_beat(1'b1, DIR_OPEN, 1'b1, 1'b1, 1'b0, -7, 1'b0);
        queue_beat(1'b1, DIR_CLOSE, 1'b1, 1'b0, 1'b1, 9, 1'b0);
        queue_beat(1'b0, DIR_OPEN, 1'b1, 1'b0, 1'b0, -9, 1'b0);
        queue_beat(1'b1, DIR_CLOSE, 1'b1, 1'b0, 1'b0, 50, 1'b0);
        queue_beat(1'b1, DIR_OPEN, 1'b1, 1'b0, 1'b0, 50, 1'b1);
        queue_beat(1'b1, DIR_CLOSE, 1'b1, 1'b0, 1'b0, POS_MIN, 1'b0);
        queue_beat(1'b1, DIR_OPEN, 1'b1, 1'b0, 1'b0, POS_MAX, 1'b1);
        drain();

        // zero sample requirement: empty directions keep their reset extremes
        write_all(0, 0, 0, 1000, 0, 0, 0);
        queue_beat(1'b0, DIR_UNKNOWN, 1'b0, 1'b0, 1'b0, 0, 1'b1);
        queue_beat(1'b1, DIR_OPEN, 1'b1, 1'b0, 1'b0, -500, 1'b0);
        queue_beat(1'b1, DIR_CLOSE, 1'b1, 1'b0, 1'b0, 500, 1'b1);
        drain();

        // every register at its extreme, fallbacks take over
        write_all(65535, POS_MIN, POS_MAX, 262143, 65535, 65535, 1048575);
        queue_beat(1'b1, DIR_OPEN, 1'b1, 1'b0, 1'b0, 0, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            randomize_limits();
            calm = (phase == 3);
            queued_beats = 0;
            while (queued_beats < 214) queue_random_batch();
            drain();
        end
        calm = 1'b0;

        if (mismatches == 0 && summary_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
